// ===== hw/rtl/lwbcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lwbcc_pkg
// Shared types and constants of the write-back block cache controller.
// ----------------------------------------------------------------------------
package lwbcc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TAG_W       = 32;
    localparam int WAY_W       = 4;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_INVAL = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_FLUSH
    } t_state;

    // what the cells do at the next edge
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_ACCESS,
        CMD_INVAL,
        CMD_FLUSH
    } t_cmd;

    // which cell claims the item
    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_MATCH,
        MODE_FREE,
        MODE_LRU,
        MODE_FLUSH
    } t_mode;

    typedef struct packed {
        t_cmd               cmd;
        t_mode              mode;
        logic [TAG_W-1:0]   blk;
        logic               is_write;
        logic               hit;
    } t_cell_cmd;

    // carried from cell to cell, lowest index first
    typedef struct packed {
        logic       match_seen;
        logic       free_seen;
        logic [1:0] dirty_cnt;
    } t_chain;

    typedef struct packed {
        logic             sel;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_cell_stat;

endpackage

// ===== hw/rtl/lwbcc_cell.sv =====
// ----------------------------------------------------------------------------
// lwbcc_cell
// One cache entry: tag, valid, dirty and recency rank, plus its link in the
// priority chain that picks the lowest matching, free or dirty entry.
// ----------------------------------------------------------------------------
module lwbcc_cell #(
    parameter int ENTRIES = lwbcc_pkg::ENTRIES_DEF,
    parameter int IDX     = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lwbcc_pkg::t_cell_cmd           i_cmd,
    input  logic [$clog2(ENTRIES)-1:0]     i_touch_rank,
    input  lwbcc_pkg::t_chain              i_chain,
    output lwbcc_pkg::t_chain              o_chain,
    output lwbcc_pkg::t_cell_stat          o_stat,
    output logic [$clog2(ENTRIES)-1:0]     o_rank
);
    import lwbcc_pkg::*;

    localparam int RW = $clog2(ENTRIES);

    logic [TAG_W-1:0] r_tag, n_tag;
    logic             r_valid, n_valid;
    logic             r_dirty, n_dirty;
    logic [RW-1:0]    r_rank, n_rank;

    logic w_match;
    logic w_dv;
    logic w_sel;

    assign w_match = r_valid && (r_tag == i_cmd.blk);
    assign w_dv    = r_valid && r_dirty;

    always_comb begin
        o_chain.match_seen = i_chain.match_seen | w_match;
        o_chain.free_seen  = i_chain.free_seen | !r_valid;
        // saturate at two: only "none", "one" or "more" matter
        if (i_chain.dirty_cnt == 2'd2) begin
            o_chain.dirty_cnt = 2'd2;
        end else begin
            o_chain.dirty_cnt = i_chain.dirty_cnt + {1'b0, w_dv};
        end
    end

    always_comb begin
        case (i_cmd.mode)
            MODE_MATCH: w_sel = w_match && !i_chain.match_seen;
            MODE_FREE:  w_sel = !r_valid && !i_chain.free_seen;
            MODE_LRU:   w_sel = (r_rank == RW'(ENTRIES - 1));
            MODE_FLUSH: w_sel = w_dv && (i_chain.dirty_cnt == 2'd0);
            default:    w_sel = 1'b0;
        endcase
    end

    assign o_stat.sel   = w_sel;
    assign o_stat.dirty = r_dirty;
    assign o_stat.tag   = r_tag;
    assign o_rank       = r_rank;

    always_comb begin
        n_tag   = r_tag;
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_rank  = r_rank;
        case (i_cmd.cmd)
            CMD_ACCESS: begin
                if (w_sel) begin
                    if (!i_cmd.hit) begin
                        n_tag = i_cmd.blk;
                    end
                    n_valid = 1'b1;
                    n_dirty = i_cmd.is_write || (i_cmd.hit && r_dirty);
                    n_rank  = '0;
                end else if (r_rank < i_touch_rank) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            CMD_INVAL: begin
                if (w_sel) begin
                    n_valid = 1'b0;
                    n_dirty = 1'b0;
                end
            end
            CMD_FLUSH: begin
                if (w_sel) begin
                    n_dirty = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= '0;
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= RW'(IDX);
        end else begin
            r_tag   <= n_tag;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_rank  <= n_rank;
        end
    end

endmodule

// ===== hw/rtl/lru_writeback_block_cache_ctrl.sv =====
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_ctrl
// Tag and replacement controller of a fully associative write-back cache.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Read, write and
// invalidate pass from acceptance to a lookup state in which the row of
// entry cells compares the tag, picks the entry through its priority chain
// and updates the ranks; the single result appears with o_valid in the cycle
// after that, and busy is already low then. A flush writes back the dirty
// entries one by one (at most 16 results) and gives no result when nothing
// is dirty; each result appears in the cycle after the one that wrote it
// back. Results are shown for one cycle only and cannot be held off, so take
// each one as o_valid pulses.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_ctrl #(
    parameter int ENTRIES = lwbcc_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_op,
    input  logic [lwbcc_pkg::TAG_W-1:0]     i_block_number,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic [lwbcc_pkg::WAY_W-1:0]     o_way,
    output logic                            o_fetch_needed,
    output logic                            o_writeback_needed,
    output logic [lwbcc_pkg::TAG_W-1:0]     o_writeback_block,
    output logic                            o_last,
    output logic [31:0]                     o_hit_total,
    output logic [31:0]                     o_miss_total
);
    import lwbcc_pkg::*;

    localparam int RW  = $clog2(ENTRIES);
    localparam int FCW = $clog2(MAX_RESULTS);

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [TAG_W-1:0] r_blk, n_blk;
    logic [FCW-1:0]   r_fcnt, n_fcnt;
    logic [31:0]      r_hits, n_hits;
    logic [31:0]      r_misses, n_misses;

    logic             r_valid, n_valid;
    logic             r_hit, n_hit;
    logic [WAY_W-1:0] r_way, n_way;
    logic             r_fetch, n_fetch;
    logic             r_wb, n_wb;
    logic [TAG_W-1:0] r_wbblk, n_wbblk;
    logic             r_last, n_last;

    t_cell_cmd        w_cmd;
    t_chain           w_chain [ENTRIES+1];
    t_cell_stat       w_stat  [ENTRIES];
    logic [RW-1:0]    w_rank  [ENTRIES];
    logic [ENTRIES-1:0] w_sel;

    logic             w_hit_any;
    logic             w_free_any;
    logic [1:0]       w_dirty_cnt;
    logic [RW-1:0]    w_idx;
    logic [RW-1:0]    w_sel_rank;
    logic [TAG_W-1:0] w_sel_tag;
    logic             w_sel_dirty;
    logic             w_is_access;

    assign w_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            lwbcc_cell #(
                .ENTRIES (ENTRIES),
                .IDX     (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_touch_rank (w_sel_rank),
                .i_chain      (w_chain[g]),
                .o_chain      (w_chain[g+1]),
                .o_stat       (w_stat[g]),
                .o_rank       (w_rank[g])
            );
        end
    endgenerate

    assign w_hit_any   = w_chain[ENTRIES].match_seen;
    assign w_free_any  = w_chain[ENTRIES].free_seen;
    assign w_dirty_cnt = w_chain[ENTRIES].dirty_cnt;
    assign w_is_access = (r_op == OP_READ) || (r_op == OP_WRITE);

    // gather the one selected entry
    always_comb begin
        w_idx       = '0;
        w_sel_rank  = '0;
        w_sel_tag   = '0;
        w_sel_dirty = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            w_sel[k] = w_stat[k].sel;
            if (w_stat[k].sel) begin
                w_idx       = w_idx | RW'(k);
                w_sel_rank  = w_sel_rank | w_rank[k];
                w_sel_tag   = w_sel_tag | w_stat[k].tag;
                w_sel_dirty = w_sel_dirty | w_stat[k].dirty;
            end
        end
    end

    // cell command
    always_comb begin
        w_cmd.blk      = r_blk;
        w_cmd.is_write = (r_op == OP_WRITE);
        w_cmd.hit      = w_hit_any;
        w_cmd.cmd      = CMD_NONE;
        w_cmd.mode     = MODE_NONE;
        case (r_state)
            ST_LOOK: begin
                if (w_is_access) begin
                    w_cmd.cmd = CMD_ACCESS;
                    if (w_hit_any) begin
                        w_cmd.mode = MODE_MATCH;
                    end else if (w_free_any) begin
                        w_cmd.mode = MODE_FREE;
                    end else begin
                        w_cmd.mode = MODE_LRU;
                    end
                end else begin
                    w_cmd.cmd  = CMD_INVAL;
                    w_cmd.mode = w_hit_any ? MODE_MATCH : MODE_NONE;
                end
            end
            ST_FLUSH: begin
                w_cmd.cmd  = CMD_FLUSH;
                w_cmd.mode = MODE_FLUSH;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_blk    = r_blk;
        n_fcnt   = r_fcnt;
        n_hits   = r_hits;
        n_misses = r_misses;
        n_valid  = 1'b0;
        n_hit    = r_hit;
        n_way    = r_way;
        n_fetch  = r_fetch;
        n_wb     = r_wb;
        n_wbblk  = r_wbblk;
        n_last   = r_last;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_op);
                    n_blk   = i_block_number;
                    n_fcnt  = '0;
                    n_state = (t_op'(i_op) == OP_FLUSH) ? ST_FLUSH : ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_valid = 1'b1;
                n_hit   = w_hit_any;
                n_way   = WAY_W'(w_idx);
                n_last  = 1'b1;
                n_fetch = (r_op == OP_READ) && !w_hit_any;
                if (w_is_access) begin
                    n_wb = !w_hit_any && !w_free_any && w_sel_dirty;
                end else begin
                    n_wb = w_hit_any && w_sel_dirty;
                end
                if (w_is_access) begin
                    n_wbblk = (!w_hit_any && !w_free_any && w_sel_dirty) ? w_sel_tag : '0;
                end else begin
                    n_wbblk = (w_hit_any && w_sel_dirty) ? w_sel_tag : '0;
                end
                if (r_op == OP_READ) begin
                    if (w_hit_any) begin
                        if (r_hits != '1) begin
                            n_hits = r_hits + 32'd1;
                        end
                    end else if (r_misses != '1) begin
                        n_misses = r_misses + 32'd1;
                    end
                end
                n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                if (w_dirty_cnt == 2'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_valid = 1'b1;
                    n_hit   = 1'b0;
                    n_way   = WAY_W'(w_idx);
                    n_fetch = 1'b0;
                    n_wb    = 1'b1;
                    n_wbblk = w_sel_tag;
                    n_last  = (w_dirty_cnt == 2'd1) || (r_fcnt == FCW'(MAX_RESULTS - 1));
                    n_fcnt  = r_fcnt + 1'b1;
                    if (n_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
            r_fcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_fcnt   <= n_fcnt;
        end
    end

    // payload: hold until the next item or result
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_blk   <= n_blk;
        r_hit   <= n_hit;
        r_way   <= n_way;
        r_fetch <= n_fetch;
        r_wb    <= n_wb;
        r_wbblk <= n_wbblk;
        r_last  <= n_last;
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_valid            = r_valid;
    assign o_hit              = r_hit;
    assign o_way              = r_way;
    assign o_fetch_needed     = r_fetch;
    assign o_writeback_needed = r_wb;
    assign o_writeback_block  = r_wbblk;
    assign o_last             = r_last;
    assign o_hit_total        = r_hits;
    assign o_miss_total       = r_misses;

    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one cell selected");

    a_lru_exists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.mode == MODE_LRU) |-> $onehot(w_sel))
        else $error("no unique least recently used entry");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state != ST_IDLE))
        else $error("result without work in progress");

    a_fetch_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fetch_needed) |-> (!o_hit && !o_writeback_needed) || !o_hit)
        else $error("fetch reported on a hit");

    a_wb_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writeback_needed) |-> (o_writeback_block == '0))
        else $error("write-back block set without write-back");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the write-back block cache tag controller: a short
// stimulus table of corner cases, then random requests over a small pool of
// block numbers so that hits, evictions, write-backs and flushes all occur.
// Every result is compared field by field against the stimulus table's
// expected values or a behavioural cache model.
module testbench;

    import lwbcc_pkg::*;

    localparam int          N_WAYS      = ENTRIES_DEF;
    localparam int          N_RANDOM    = 205;
    localparam int          CALM_TAIL   = 40;
    localparam int          POOL_SIZE   = 20;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  way;
        logic              fetch;
        logic              wb;
        logic [TAG_W-1:0]  wb_blk;
        logic              last;
        logic [31:0]       hits;
        logic [31:0]       misses;
    } t_outcome;

    typedef struct {
        t_op               op;
        logic [TAG_W-1:0]  blk;
        bit                typed;
        t_outcome          want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [1:0]            i_op = 2'd0;
    logic [TAG_W-1:0]      i_block_number = '0;
    logic                  busy;
    logic                  o_valid;
    logic                  o_hit;
    logic [WAY_W-1:0]      o_way;
    logic                  o_fetch_needed;
    logic                  o_writeback_needed;
    logic [TAG_W-1:0]      o_writeback_block;
    logic                  o_last;
    logic [31:0]           o_hit_total;
    logic [31:0]           o_miss_total;

    // cache mirror
    logic [TAG_W-1:0]      tag_mirror [N_WAYS];
    bit                    tag_valid  [N_WAYS];
    bit                    tag_dirty  [N_WAYS];
    int                    lru_rank   [N_WAYS];
    logic [31:0]           read_hits;
    logic [31:0]           read_misses;

    t_outcome              step_out [$];
    t_outcome              outcome_q [$];
    t_stim_row             stim_rows [$];
    logic [TAG_W-1:0]      blk_pool [POOL_SIZE];

    int                    mismatches = 0;
    int                    results_seen = 0;
    int                    hits_seen = 0;
    int                    wb_seen = 0;
    int                    fetch_seen = 0;
    int                    op_count [4] = '{0, 0, 0, 0};

    lru_writeback_block_cache_ctrl uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_block_number     (i_block_number),
        .o_valid            (o_valid),
        .o_hit              (o_hit),
        .o_way              (o_way),
        .o_fetch_needed     (o_fetch_needed),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_block  (o_writeback_block),
        .o_last             (o_last),
        .o_hit_total        (o_hit_total),
        .o_miss_total       (o_miss_total)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_outcome mk(input bit hit, input int way, input bit fetch,
                                    input bit wb, input logic [TAG_W-1:0] wb_blk,
                                    input bit last, input logic [31:0] hits,
                                    input logic [31:0] misses);
        t_outcome r;
        r.hit    = hit;
        r.way    = way[WAY_W-1:0];
        r.fetch  = fetch;
        r.wb     = wb;
        r.wb_blk = wb_blk;
        r.last   = last;
        r.hits   = hits;
        r.misses = misses;
        return r;
    endfunction

    // Work out the results of one request and advance the mirror.
    task automatic predict_request(input t_op op, input logic [TAG_W-1:0] blk);
        int        found;
        int        slot;
        int        old_rank;
        int        n;
        bit        wb;
        logic [TAG_W-1:0] wb_tag;
        t_outcome  tail;
        step_out.delete();
        found = -1;
        slot = -1;
        wb = 1'b0;
        wb_tag = '0;
        n = 0;
        if (op != OP_FLUSH) begin
            for (int i = 0; i < N_WAYS; i++)
                if (found < 0 && tag_valid[i] && tag_mirror[i] == blk) found = i;
        end
        case (op)
            OP_READ, OP_WRITE: begin
                if (found >= 0) begin
                    slot = found;
                    if (op == OP_READ && read_hits != COUNT_MAX) read_hits++;
                end else begin
                    if (op == OP_READ && read_misses != COUNT_MAX) read_misses++;
                    for (int i = 0; i < N_WAYS; i++)
                        if (slot < 0 && !tag_valid[i]) slot = i;
                    if (slot < 0) begin
                        for (int i = 0; i < N_WAYS; i++)
                            if (lru_rank[i] == N_WAYS - 1) slot = i;
                        if (tag_dirty[slot]) begin
                            wb = 1'b1;
                            wb_tag = tag_mirror[slot];
                        end
                    end
                    tag_mirror[slot] = blk;
                    tag_valid[slot] = 1'b1;
                    tag_dirty[slot] = 1'b0;
                end
                if (op == OP_WRITE) tag_dirty[slot] = 1'b1;
                // promote to most recent, age everything that was newer
                old_rank = lru_rank[slot];
                for (int i = 0; i < N_WAYS; i++)
                    if (lru_rank[i] < old_rank) lru_rank[i]++;
                lru_rank[slot] = 0;
                step_out.push_back(mk(found >= 0, slot, found < 0 && op == OP_READ,
                                      wb, wb_tag, 1'b1, read_hits, read_misses));
            end
            OP_INVAL: begin
                if (found < 0) begin
                    step_out.push_back(mk(0, 0, 0, 0, '0, 1'b1, read_hits, read_misses));
                end else begin
                    wb = tag_dirty[found];
                    step_out.push_back(mk(1, found, 0, wb, wb ? tag_mirror[found] : '0,
                                          1'b1, read_hits, read_misses));
                    tag_valid[found] = 1'b0;
                    tag_dirty[found] = 1'b0;
                end
            end
            default: begin
                for (int i = 0; i < N_WAYS; i++) begin
                    if (n < MAX_RESULTS && tag_valid[i] && tag_dirty[i]) begin
                        step_out.push_back(mk(0, i, 0, 1, tag_mirror[i], 1'b0,
                                              read_hits, read_misses));
                        tag_dirty[i] = 1'b0;
                        n++;
                    end
                end
                if (n > 0) begin
                    tail = step_out.pop_back();
                    tail.last = 1'b1;
                    step_out.push_back(tail);
                end
            end
        endcase
    endtask

    // Present one item and hold it until the controller takes it.
    task automatic issue_request(input t_op op, input logic [TAG_W-1:0] blk);
        start <= 1'b1;
        i_op <= op;
        i_block_number <= blk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        op_count[op]++;
        predict_request(op, blk);
    endtask

    task automatic sender_gap(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_op op, input logic [TAG_W-1:0] blk, input bit typed,
                           input t_outcome want);
        t_stim_row row;
        row.op = op;
        row.blk = blk;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, fname, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (o_hit === 1'b1) hits_seen++;
            if (o_writeback_needed === 1'b1) wb_seen++;
            if (o_fetch_needed === 1'b1) fetch_seen++;
            if (outcome_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual way %0d", $time, o_way);
            end else begin
                want = outcome_q.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("way", 32'(want.way), 32'(o_way));
                check_field("fetch_needed", 32'(want.fetch), 32'(o_fetch_needed));
                check_field("writeback_needed", 32'(want.wb), 32'(o_writeback_needed));
                check_field("writeback_block", want.wb_blk, o_writeback_block);
                check_field("last", 32'(want.last), 32'(o_last));
                check_field("hit_total", want.hits, o_hit_total);
                check_field("miss_total", want.misses, o_miss_total);
            end
        end
    end

    initial begin : stimulus
        t_op              op;
        logic [TAG_W-1:0] blk;
        int               pick;

        for (int i = 0; i < N_WAYS; i++) begin
            tag_mirror[i] = '0;
            tag_valid[i] = 1'b0;
            tag_dirty[i] = 1'b0;
            lru_rank[i] = i;
        end
        read_hits = '0;
        read_misses = '0;

        // corner cases: zero tag after reset is not a hit, all-ones tag, refill
        // of a freed entry, eviction of clean and dirty LRU entries, flushes
        add_row(OP_FLUSH, '0, 1'b0, '0);
        add_row(OP_READ, 32'h0, 1'b1, mk(0, 0, 1, 0, '0, 1, 0, 1));
        add_row(OP_INVAL, 32'hFFFF_FFFF, 1'b1, mk(0, 0, 0, 0, '0, 1, 0, 1));
        add_row(OP_READ, 32'h0, 1'b1, mk(1, 0, 0, 0, '0, 1, 1, 1));
        add_row(OP_WRITE, 32'hFFFF_FFFF, 1'b1, mk(0, 1, 0, 0, '0, 1, 1, 1));
        add_row(OP_INVAL, 32'hFFFF_FFFF, 1'b1, mk(1, 1, 0, 1, 32'hFFFF_FFFF, 1, 1, 1));
        add_row(OP_WRITE, 32'hFFFF_FFFF, 1'b0, '0);
        for (int k = 2; k < N_WAYS; k++)
            add_row((k % 2 == 0) ? OP_WRITE : OP_READ, 32'h10 + k, 1'b0, '0);
        add_row(OP_READ, 32'hA5A5_A5A5, 1'b0, '0);
        add_row(OP_WRITE, 32'h5A5A_5A5A, 1'b0, '0);
        add_row(OP_READ, 32'h5A5A_5A5A, 1'b0, '0);
        add_row(OP_FLUSH, '0, 1'b0, '0);
        add_row(OP_FLUSH, '0, 1'b0, '0);

        blk_pool[0] = 32'h0;
        blk_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) blk_pool[i] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            issue_request(stim_rows[r].op, stim_rows[r].blk);
            if (stim_rows[r].typed) outcome_q.push_back(stim_rows[r].want);
            else foreach (step_out[k]) outcome_q.push_back(step_out[k]);
            sender_gap(1'b1);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) op = OP_READ;
            else if (pick < 75) op = OP_WRITE;
            else if (pick < 90) op = OP_INVAL;
            else op = OP_FLUSH;
            // keep most traffic on a small set so that hits and evictions recur
            if ($urandom_range(0, 4) != 0) blk = blk_pool[$urandom_range(0, POOL_SIZE - 1)];
            else blk = $urandom;
            issue_request(op, blk);
            foreach (step_out[k]) outcome_q.push_back(step_out[k]);
            if (n == N_RANDOM / 2) begin
                // hold off until the controller has drained
                start <= 1'b0;
                @(posedge i_clk);
                while (outcome_q.size() != 0) @(posedge i_clk);
            end else begin
                sender_gap(n < N_RANDOM - CALM_TAIL);
            end
        end
        start <= 1'b0;

        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        $display("Summary: %0d reads, %0d writes, %0d invalidates, %0d flushes issued",
                 op_count[OP_READ], op_count[OP_WRITE], op_count[OP_INVAL],
                 op_count[OP_FLUSH]);
        $display("Summary: %0d results checked, %0d hits, %0d fetches, %0d write-backs",
                 results_seen, hits_seen, fetch_seen, wb_seen);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
